FILE: src/itwa_pkg.sv
// ----------------------------------------------------------------------------
// itwa_pkg
// Shared types and constants for the interval time window averager.
// ----------------------------------------------------------------------------
package itwa_pkg;

    // Field widths
    localparam int SLOT_W    = 32;   // ticks per slot, timestamp width
    localparam int FUNC_W    = 2;
    localparam int CNT_OUT_W = 7;    // reported slot count width
    localparam int SUM_S_W   = 37;   // running sum over the short window
    localparam int SUM_L_W   = 39;   // running sum over the long window
    localparam int KS_W      = 5;    // short window divisor, at most 25
    localparam int KL_W      = 7;    // long window divisor, at most 100

    // Window edges: a window of E-1 completed slots
    localparam int SHORT_EDGE = 26;
    localparam int LONG_EDGE  = 101;

    // Default ring depth
    localparam int DEPTH_DEF = 101;

    // Command codes
    localparam logic [FUNC_W-1:0] FN_START = 2'd0;
    localparam logic [FUNC_W-1:0] FN_END   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_NEXT  = 2'd2;

    // Input word
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] timestamp;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [SLOT_W-1:0]    last_slot;
        logic [SLOT_W-1:0]    avg_window_short;
        logic [SLOT_W-1:0]    avg_window_long;
        logic [CNT_OUT_W-1:0] slot_count;
        logic                 interval_open;
    } t_out_word;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture input word
        logic exec;        // start or close an interval
        logic rd_short;    // read slot leaving the short window
        logic upd_short;   // update short sum
        logic push;        // update long sum, retire current slot
        logic div_start;   // launch both divisions
        logic cap_avg;     // capture quotients
        logic out_load;    // load result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              div_busy;
        logic              out_free;
    } t_sts;

endpackage

FILE: src/itwa_div.sv
// ----------------------------------------------------------------------------
// itwa_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itwa_div #(
    parameter int NW = 39,   // dividend width
    parameter int DW = 7     // divisor width
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_quot;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_div;
    logic [DW:0]     trial;
    logic            fits;

    // Shift next dividend bit into the partial remainder
    assign trial = {r_rem, r_quot[NW-1]};
    assign fits  = (trial >= {1'b0, r_div});

    // Iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(NW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_cnt != '0) begin
            if (fits) begin
                r_rem  <= DW'(trial - {1'b0, r_div});
                r_quot <= {r_quot[NW-2:0], 1'b1};
            end else begin
                r_rem  <= trial[DW-1:0];
                r_quot <= {r_quot[NW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

FILE: src/itwa_datapath.sv
// ----------------------------------------------------------------------------
// itwa_datapath
// Interval timing, slot ring, running sums, dividers and result register.
// ----------------------------------------------------------------------------
module itwa_datapath #(
    parameter int DEPTH = itwa_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itwa_pkg::t_in_word  i_in_word,
    input  itwa_pkg::t_cmd      i_cmd,
    output itwa_pkg::t_sts      o_sts,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output itwa_pkg::t_out_word o_out_word
);

    import itwa_pkg::*;

    localparam int PW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int LONG_LAST = (DEPTH - 1 < LONG_EDGE - 1) ? DEPTH - 1 : LONG_EDGE - 1;

    localparam logic [PW-1:0] BACK_S = PW'(SHORT_EDGE - 1);
    localparam logic [PW-1:0] BACK_L = PW'(LONG_LAST);
    localparam logic [PW-1:0] WRAP_S = PW'(DEPTH - (SHORT_EDGE - 1));
    localparam logic [PW-1:0] WRAP_L = PW'(DEPTH - LONG_LAST);
    localparam logic [PW-1:0] HEAD_MAX = PW'(DEPTH - 1);

    // Item and interval state
    logic [FUNC_W-1:0] r_func;
    logic [SLOT_W-1:0] r_ts;
    logic [SLOT_W-1:0] r_elapsed;
    logic              r_open;
    logic [SLOT_W-1:0] r_stamp;

    // Slot state
    logic [SLOT_W-1:0] r_cur;     // current slot, kept out of the ring
    logic [SLOT_W-1:0] r_last;    // most recent completed slot
    logic [PW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [SUM_S_W-1:0] r_sum_s;
    logic [SUM_L_W-1:0] r_sum_l;
    logic [SLOT_W-1:0] r_avg_s;
    logic [SLOT_W-1:0] r_avg_l;

    // Ring of completed slots
    logic [SLOT_W-1:0] r_ring [DEPTH];
    logic [SLOT_W-1:0] r_rd_data;
    logic [PW-1:0]     rd_addr;
    logic [PW-1:0]     addr_s;
    logic [PW-1:0]     addr_l;

    // Result register
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic [SLOT_W:0]    cur_sum;
    logic [SLOT_W-1:0]  cur_sat;
    logic [SLOT_W-1:0]  add_cur;
    logic [SLOT_W-1:0]  drop_s;
    logic [SLOT_W-1:0]  drop_l;
    logic [KS_W-1:0]    ks;
    logic [KL_W-1:0]    kl;
    logic               busy_s;
    logic               busy_l;
    logic [SUM_S_W-1:0] quot_s;
    logic [SUM_L_W-1:0] quot_l;
    logic               out_take;

    // Saturating accumulate of the closed interval
    assign cur_sum = {1'b0, r_cur} + {1'b0, r_elapsed};
    assign cur_sat = cur_sum[SLOT_W] ? '1 : cur_sum[SLOT_W-1:0];

    // Ring positions of the slots that leave each window
    assign addr_s  = (r_head >= BACK_S) ? r_head - BACK_S : r_head + WRAP_S;
    assign addr_l  = (r_head >= BACK_L) ? r_head - BACK_L : r_head + WRAP_L;
    assign rd_addr = i_cmd.rd_short ? addr_s : addr_l;

    // Sum terms
    assign add_cur = (r_count != '0) ? r_cur : '0;
    assign drop_s  = (r_count > SHORT_EDGE - 1) ? r_rd_data : '0;
    assign drop_l  = (r_count > LONG_LAST) ? r_rd_data : '0;

    // Window divisors from the slot count
    always_comb begin
        if (r_count >= SHORT_EDGE) begin
            ks = KS_W'(SHORT_EDGE - 1);
        end else if (r_count == '0) begin
            ks = '0;
        end else begin
            ks = KS_W'(r_count - 1'b1);
        end
        if (r_count >= LONG_EDGE) begin
            kl = KL_W'(LONG_EDGE - 1);
        end else if (r_count == '0) begin
            kl = '0;
        end else begin
            kl = KL_W'(r_count - 1'b1);
        end
    end

    // Interval tracking and current slot update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_stamp <= '0;
            r_cur   <= '0;
        end else begin
            if (i_cmd.exec) begin
                if (r_func == FN_START) begin
                    if (!r_open) begin
                        r_open  <= 1'b1;
                        r_stamp <= r_ts;
                    end
                end else if (r_func == FN_END || r_func == FN_NEXT) begin
                    if (r_open) begin
                        r_open <= 1'b0;
                        if (r_count != '0) begin
                            r_cur <= cur_sat;
                        end
                    end
                end
            end
            if (i_cmd.push) begin
                r_cur <= '0;
            end
        end
    end

    // Latched word and elapsed ticks against the open stamp
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_in_word.func;
            r_ts      <= i_in_word.timestamp;
            r_elapsed <= i_in_word.timestamp - r_stamp;
        end
    end

    // Running sums, head and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_s <= '0;
            r_sum_l <= '0;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.upd_short) begin
                r_sum_s <= r_sum_s + SUM_S_W'(add_cur) - SUM_S_W'(drop_s);
            end
            if (i_cmd.push) begin
                r_sum_l <= r_sum_l + SUM_L_W'(add_cur) - SUM_L_W'(drop_l);
                r_head  <= (r_head == HEAD_MAX) ? '0 : r_head + 1'b1;
                if (r_count < CW'(DEPTH)) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Last completed slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_last <= r_cur;
        end
    end

    // Slot ring: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_ring[r_head] <= r_cur;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    // Window means
    itwa_div #(
        .NW (SUM_S_W),
        .DW (KS_W)
    ) u_div_short (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum_s),
        .i_divisor  (ks),
        .o_busy     (busy_s),
        .o_quot     (quot_s)
    );

    itwa_div #(
        .NW (SUM_L_W),
        .DW (KL_W)
    ) u_div_long (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum_l),
        .i_divisor  (kl),
        .o_busy     (busy_l),
        .o_quot     (quot_l)
    );

    // Empty window reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_s <= '0;
            r_avg_l <= '0;
        end else if (i_cmd.cap_avg) begin
            r_avg_s <= (ks == '0) ? '0 : quot_s[SLOT_W-1:0];
            r_avg_l <= (kl == '0) ? '0 : quot_l[SLOT_W-1:0];
        end
    end

    // Result register
    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word.last_slot        <= (r_count >= 2) ? r_last : '0;
            r_out_word.avg_window_short <= r_avg_s;
            r_out_word.avg_window_long  <= r_avg_l;
            r_out_word.slot_count       <= CNT_OUT_W'(r_count);
            r_out_word.interval_open    <= r_open;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out_word;
    assign o_sts.func     = r_func;
    assign o_sts.div_busy = busy_s || busy_l;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

endmodule

FILE: src/itwa_ctrl.sv
// ----------------------------------------------------------------------------
// itwa_ctrl
// Per-word sequencer: interval update, next-slot push and division, result.
// ----------------------------------------------------------------------------
module itwa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output itwa_pkg::t_cmd o_cmd,
    input  itwa_pkg::t_sts i_sts
);

    import itwa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_S,
        S_RD_L,
        S_PUSH,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = (i_sts.func == FN_NEXT) ? S_RD_S : S_OUT;
            end
            S_RD_S: begin
                o_cmd.rd_short = 1'b1;
                n_state        = S_RD_L;
            end
            S_RD_L: begin
                o_cmd.upd_short = 1'b1;
                n_state         = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.cap_avg = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: src/interval_time_window_averager_core.sv
// ----------------------------------------------------------------------------
// interval_time_window_averager_core
// Busy-time monitor with short and long windowed means of slot durations.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall / i_in_word. A word carries a command
// (start, end or next slot) and a free-running timestamp. A word is taken at
// a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall / o_out_word. Every input word
// yields exactly one result word: last completed slot, means over up to 25
// and up to 100 completed slots, slot count and interval state.
// Sequence: start, end and unused commands go from the interval update
// straight to the result load. A next-slot command steps through the
// interval update, ring reads, sum updates and a launch; then two serial
// dividers run side by side, one quotient bit per cycle over the 39-bit
// long-window sum; then the means are captured and the result loaded. One
// word is in work at a time; the next is taken in the cycle after the load.
// A finished result sits in the output register; the next word is accepted
// while it waits. If the receiver stalls, the block holds its next result
// until the register frees, then goes idle.
// Reset (synchronous, active low) clears the interval, counts, sums and
// means; the slot ring itself needs no clearing.
// ----------------------------------------------------------------------------
module interval_time_window_averager_core #(
    parameter int DEPTH = itwa_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  itwa_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output itwa_pkg::t_out_word o_out_word
);

    import itwa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    itwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Datapath
    itwa_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
